/* design/ascii_number_parser_with_base_defines.svh */
// assertion macros for the ascii number parser
// used by the top level, expects i_clk and i_rst_n in scope
`ifndef ASCII_NUMBER_PARSER_WITH_BASE_DEFINES_SVH
`define ASCII_NUMBER_PARSER_WITH_BASE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ANP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("anp assertion failed");

// next-cycle implication, checked outside reset
`define ANP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("anp assertion failed");

`endif

/* design/anp_pkg.sv */
// types, character constants and decode functions for the ascii number parser
// no dependencies
package anp_pkg;

    localparam int VALUE_W = 16;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] HEX_UC_OFS = 8'd55;
    localparam logic [7:0] HEX_LC_OFS = 8'd87;

    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_DEC = 2'd2
    } t_radix;

    typedef struct packed {
        logic [7:0] ch;
        logic       reuse_base;
    } t_item;

    typedef struct packed {
        logic  ok;
        t_radix radix;
    } t_base_dec;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit_dec;

    function automatic t_base_dec base_decode(input logic [7:0] c);
        t_base_dec r;
        r.ok    = 1'b1;
        r.radix = RADIX_BIN;
        unique case (c) inside
            8'h62, 8'h42: r.radix = RADIX_BIN;
            8'h68, 8'h48: r.radix = RADIX_HEX;
            8'h64, 8'h44: r.radix = RADIX_DEC;
            default:      r.ok    = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_digit_dec digit_decode(input logic [7:0] c, input t_radix radix);
        t_digit_dec r;
        logic [7:0] dec_v;
        logic [7:0] uc_v;
        logic [7:0] lc_v;
        dec_v = c - ASCII_ZERO;
        uc_v  = c - HEX_UC_OFS;
        lc_v  = c - HEX_LC_OFS;
        r.ok  = 1'b0;
        r.val = dec_v[3:0];
        unique case (radix)
            RADIX_BIN: begin
                r.ok = (c == 8'h30) || (c == 8'h31);
            end
            RADIX_HEX: begin
                case (c) inside
                    [8'h30:8'h39]: r.ok = 1'b1;
                    [8'h41:8'h46]: begin
                        r.ok  = 1'b1;
                        r.val = uc_v[3:0];
                    end
                    [8'h61:8'h66]: begin
                        r.ok  = 1'b1;
                        r.val = lc_v[3:0];
                    end
                    default: r.ok = 1'b0;
                endcase
            end
            RADIX_DEC: begin
                r.ok = (c >= 8'h30) && (c <= 8'h39);
            end
            default: r.ok = 1'b0;
        endcase
        return r;
    endfunction

endpackage

/* design/anp_in_stage.sv */
// input register stage: holds one character transfer until the core takes it
// depends on anp_pkg
module anp_in_stage
    import anp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_item i_item,
    output logic  o_item_valid,
    output t_item o_item,
    input  logic  i_take
);

    logic  r_valid;
    t_item r_item;
    logic  w_accept;

    assign o_in_stall   = r_valid && !i_take;
    assign w_accept     = i_in_valid && !o_in_stall;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

endmodule

/* design/anp_core.sv */
// parser state, per-character next-state logic and result register
// depends on anp_pkg
module anp_core
    import anp_pkg::*;
#(
    parameter int VALUE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_item_valid,
    input  t_item              i_item,
    output logic               o_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_error
);

    logic                  r_keep_base;
    logic                  r_busy;
    t_radix                r_radix;
    logic [7:0]            r_saved;
    logic [VALUE_BITS-1:0] r_accum;
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_value;
    logic                  r_error;

    logic                  n_busy;
    t_radix                n_radix;
    logic [7:0]            n_saved;
    logic [VALUE_BITS-1:0] n_accum;

    t_base_dec             w_bdec_saved;
    t_base_dec             w_bdec_ch;
    t_digit_dec            w_ddec;
    t_radix                w_eff_radix;
    logic [VALUE_BITS-1:0] w_eff_accum;
    logic [VALUE_BITS-1:0] w_scaled;
    logic [VALUE_BITS-1:0] w_mac;
    logic                  w_term;
    logic                  w_use_digit;
    logic                  w_emit;
    logic                  w_err;
    logic [VALUE_BITS-1:0] w_emit_val;
    logic [VALUE_W-1:0]    w_emit_val16;

    assign o_take = i_item_valid && (!r_out_valid || !i_out_stall);

    assign w_bdec_saved = base_decode(r_saved);
    assign w_bdec_ch    = base_decode(i_item.ch);
    assign w_eff_radix  = r_busy ? r_radix : w_bdec_saved.radix;
    assign w_eff_accum  = r_busy ? r_accum : '0;
    assign w_ddec       = digit_decode(i_item.ch, w_eff_radix);
    assign w_term       = (i_item.ch == CH_NUL) || (i_item.ch == CH_SPACE)
                          || (i_item.ch == CH_DOT);

    always_comb begin
        case (w_eff_radix)
            RADIX_BIN: w_scaled = w_eff_accum << 1;
            RADIX_HEX: w_scaled = w_eff_accum << 4;
            default:   w_scaled = (w_eff_accum << 3) + (w_eff_accum << 1);
        endcase
    end

    assign w_mac = w_scaled + VALUE_BITS'(w_ddec.val);

    always_comb begin
        n_busy      = r_busy;
        n_radix     = r_radix;
        n_saved     = r_saved;
        n_accum     = r_accum;
        w_emit      = 1'b0;
        w_err       = 1'b0;
        w_emit_val  = '0;
        w_use_digit = 1'b0;
        if (r_busy) begin
            w_use_digit = 1'b1;
        end else if (i_item.reuse_base) begin
            if (!w_bdec_saved.ok) begin
                w_emit = 1'b1;
                w_err  = 1'b1;
            end else begin
                w_use_digit = 1'b1;
            end
        end else begin
            if (r_keep_base) begin
                n_saved = i_item.ch;
            end
            if (!w_bdec_ch.ok) begin
                w_emit  = 1'b1;
                w_err   = 1'b1;
                n_accum = '0;
            end else begin
                n_busy  = 1'b1;
                n_radix = w_bdec_ch.radix;
                n_accum = '0;
            end
        end
        if (w_use_digit) begin
            if (w_term) begin
                w_emit     = 1'b1;
                w_emit_val = w_eff_accum;
                n_busy     = 1'b0;
                n_accum    = '0;
            end else if (!w_ddec.ok) begin
                w_emit  = 1'b1;
                w_err   = 1'b1;
                n_busy  = 1'b0;
                n_accum = '0;
            end else begin
                n_busy  = 1'b1;
                n_radix = w_eff_radix;
                n_accum = w_mac;
            end
        end
    end

    generate
        if (VALUE_BITS >= VALUE_W) begin : g_trunc
            assign w_emit_val16 = w_emit_val[VALUE_W-1:0];
        end else begin : g_extend
            assign w_emit_val16 = {{(VALUE_W-VALUE_BITS){1'b0}}, w_emit_val};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_base <= 1'b0;
        end else if (i_cfg_we) begin
            r_keep_base <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_radix <= RADIX_BIN;
            r_saved <= '0;
            r_accum <= '0;
        end else if (o_take) begin
            r_busy  <= n_busy;
            r_radix <= n_radix;
            r_saved <= n_saved;
            r_accum <= n_accum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= w_emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && w_emit) begin
            r_value <= w_emit_val16;
            r_error <= w_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_error     = r_error;

endmodule

/* design/ascii_number_parser_with_base.sv */
// channel  | direction | handshake               | payload
// in       | input     | i_in_valid / o_in_stall   | i_ch, i_reuse_base
// out      | output    | o_out_valid / i_out_stall | o_value, o_error
// cfg      | input     | i_cfg_we                  | i_cfg_wdata (keep_base)
//
// one character per cycle while the output is not stalled
// a result passes one input register plus one result register around the decode/multiply-add
// i_rst_n is synchronous, active low; clears parser state, keep_base and both valids
// a stalled result holds while the next character still moves into the input register
// depends on anp_pkg, anp_in_stage, anp_core and the defines header
`include "ascii_number_parser_with_base_defines.svh"

module ascii_number_parser_with_base
    import anp_pkg::*;
#(
    parameter int VALUE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_ch,
    input  logic               i_reuse_base,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_error
);

    t_item w_in_item;
    t_item w_pend_item;
    logic  w_pend_valid;
    logic  w_take;

    assign w_in_item.ch         = i_ch;
    assign w_in_item.reuse_base = i_reuse_base;

    anp_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_item       (w_in_item),
        .o_item_valid (w_pend_valid),
        .o_item       (w_pend_item),
        .i_take       (w_take)
    );

    anp_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (w_pend_valid),
        .i_item       (w_pend_item),
        .o_take       (w_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_error      (o_error)
    );

    `ANP_ASSERT_NOW(a_err_value_zero, o_out_valid && o_error, o_value == '0)
    `ANP_ASSERT_NOW(a_empty_no_stall, !w_pend_valid, !o_in_stall)
    `ANP_ASSERT_NOW(a_take_needs_item, w_take, w_pend_valid)
    `ANP_ASSERT_NEXT(a_drain, w_pend_valid && !o_out_valid && !i_in_valid, !w_pend_valid)

endmodule
